### sv/dte_pkg.sv
// shared widths, constants and helper functions for the date to epoch seconds core
// no dependencies
package dte_pkg;

  localparam int YearW = 12;
  localparam int DayW = 11;
  localparam int HourW = 8;
  localparam int MinW = 12;
  localparam int SecW = 13;
  localparam int EpochW = 37;
  localparam int DaysW = 20;
  localparam int TodW = 17;
  localparam int NYears = 6;

  localparam logic [12:0] EpochYear = 13'd1970;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [8:0] LeapsBeforeEpoch = 9'd477;

  // normalized time of day plus leap flags for years year-3 .. year+2
  typedef struct packed {
    logic [YearW-1:0] year;
    logic signed [11:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [NYears-1:0] leap;
  } norm_t;

  // floor(u / 60) for u below 15360
  function automatic logic [7:0] div60(input logic [14:0] u);
    logic [29:0] p;
    begin
      p = 30'(u) * 30'd17477;
      div60 = 8'(p >> 20);
    end
  endfunction

  // leap test on a year offset by +400 so the value is never negative
  function automatic logic is_leap(input logic [12:0] ya);
    logic [25:0] p;
    logic [6:0] q100;
    logic [12:0] rem100;
    begin
      p = 26'(ya) * 26'd5243;
      q100 = 7'(p >> 19);
      rem100 = ya - 13'(q100 * 7'd100);
      is_leap = (ya[1:0] == 2'd0) && ((rem100 != 13'd0) || (q100[1:0] == 2'd0));
    end
  endfunction

endpackage

### sv/dte_normalize.sv
// three stage floor carry: second into minute, minute into hour, hour into day
// depends on dte_pkg
module dte_normalize (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_in,
  input  logic [dte_pkg::YearW-1:0]      year,
  input  logic signed [dte_pkg::DayW-1:0]  day_of_year,
  input  logic signed [dte_pkg::HourW-1:0] hour,
  input  logic signed [dte_pkg::MinW-1:0]  minute,
  input  logic signed [dte_pkg::SecW-1:0]  second,
  output logic                           valid_out,
  output dte_pkg::norm_t                 norm
);

  logic [2:0] vld_r;

  // stage 1
  logic [dte_pkg::YearW-1:0] y1_r;
  logic [10:0] d1_r;
  logic [7:0]  h1_r;
  logic [12:0] m1_r;
  logic [5:0]  s1_r;
  // stage 2
  logic [dte_pkg::YearW-1:0] y2_r;
  logic [10:0] d2_r;
  logic [8:0]  h2_r;
  logic [5:0]  m2_r;
  logic [5:0]  s2_r;
  logic [dte_pkg::NYears-1:0] leap2_r;
  // stage 3
  dte_pkg::norm_t n3_r;

  logic [14:0] s_off;
  logic [7:0]  qs;
  logic [12:0] m_off;
  logic [7:0]  qm;
  logic [8:0]  h_off;
  logic [24:0] ph;
  logic [3:0]  qh;
  logic [dte_pkg::NYears-1:0] leap_nxt;

  always_comb begin
    s_off = {{2{second[12]}}, second} + 15'd4140;
    qs = dte_pkg::div60(s_off);
    m_off = m1_r + 13'd2220;
    qm = dte_pkg::div60({2'b00, m_off});
    h_off = h2_r + 9'd168;
    ph = 25'(h_off) * 25'd2731;
    qh = 4'(ph >> 16);
    for (int k = 0; k < dte_pkg::NYears; k++) begin
      leap_nxt[k] = dte_pkg::is_leap({1'b0, y1_r} + 13'(397 + k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_r <= year;
      d1_r <= day_of_year;
      h1_r <= hour;
      s1_r <= 6'(s_off - 15'(qs * 8'd60));
      m1_r <= {minute[11], minute} + {5'b0, qs} - 13'd69;

      y2_r <= y1_r;
      d2_r <= d1_r;
      s2_r <= s1_r;
      m2_r <= 6'(m_off - 13'(qm * 8'd60));
      h2_r <= {h1_r[7], h1_r} + {1'b0, qm} - 9'd37;
      leap2_r <= leap_nxt;

      n3_r.year <= y2_r;
      n3_r.second <= s2_r;
      n3_r.minute <= m2_r;
      n3_r.hour <= 5'(h_off - 9'(qh * 5'd24));
      n3_r.day <= {d2_r[10], d2_r} + {8'b0, qh} - 12'd7;
      n3_r.leap <= leap2_r;
    end
  end

  assign valid_out = vld_r[2];
  assign norm = n3_r;

endmodule

### sv/dte_days.sv
// two stage calendar: carry day of year into year, then count days since the epoch
// depends on dte_pkg
module dte_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  dte_pkg::norm_t                norm,
  output logic                          valid_out,
  output logic [dte_pkg::DaysW-1:0]     days,
  output logic [dte_pkg::TodW-1:0]      tod
);

  logic [1:0] vld_r;
  // two bits wider than the year field: a forward carry can pass 4095
  logic signed [13:0] yf_r;
  logic [8:0] dn_r;
  logic [dte_pkg::TodW-1:0] tod4_r;
  logic [dte_pkg::TodW-1:0] tod5_r;
  logic [dte_pkg::DaysW-1:0] days_r;

  logic signed [11:0] len [dte_pkg::NYears];
  logic signed [11:0] a1, a2, a3, b1, b2;
  logic signed [2:0] kk;
  logic signed [11:0] dn;
  logic [dte_pkg::TodW-1:0] tod_nxt;

  logic after;
  logic [12:0] n;
  logic [25:0] p;
  logic [6:0] q100;
  logic [12:0] leaps;
  logic [dte_pkg::DaysW-1:0] whole_days;
  logic [dte_pkg::DaysW-1:0] days_nxt;

  always_comb begin
    for (int k = 0; k < dte_pkg::NYears; k++) begin
      len[k] = 12'sd365 + 12'(norm.leap[k]);
    end
    // index 3 is this year, lower indexes earlier years
    a1 = norm.day + len[2];
    a2 = a1 + len[1];
    a3 = a2 + len[0];
    b1 = norm.day - len[3];
    b2 = b1 - len[4];
    if (norm.day <= 12'sd0) begin
      if (a1 > 12'sd0) begin
        kk = -3'sd1; dn = a1;
      end else if (a2 > 12'sd0) begin
        kk = -3'sd2; dn = a2;
      end else begin
        kk = -3'sd3; dn = a3;
      end
    end else if (norm.day <= len[3]) begin
      kk = 3'sd0; dn = norm.day;
    end else if (b1 <= len[4]) begin
      kk = 3'sd1; dn = b1;
    end else begin
      kk = 3'sd2; dn = b2;
    end
    tod_nxt = 17'(norm.hour * dte_pkg::SecsPerHour) + 17'(norm.minute * 6'd60)
            + 17'(norm.second);

    after = yf_r > $signed({2'b00, dte_pkg::EpochYear[11:0]});
    n = 13'(yf_r) - 13'd1;
    p = 26'(n) * 26'd5243;
    q100 = 7'(p >> 19);
    leaps = (n >> 2) - 13'(q100) + 13'(q100 >> 2);
    whole_days = 20'(20'(13'(yf_r) - dte_pkg::EpochYear) * 20'd365)
               + 20'(leaps) - 20'(dte_pkg::LeapsBeforeEpoch);
    days_nxt = 20'(dn_r) - 20'd1 + (after ? whole_days : 20'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yf_r <= $signed({2'b00, norm.year}) + 14'(kk);
      dn_r <= 9'(dn);
      tod4_r <= tod_nxt;
      days_r <= days_nxt;
      tod5_r <= tod4_r;
    end
  end

  assign valid_out = vld_r[1];
  assign days = days_r;
  assign tod = tod5_r;

endmodule

### sv/datetime_to_epoch_seconds_core.sv
// top level: normalize, calendar and final seconds stage with a shared stall
// depends on dte_pkg, dte_normalize, dte_days
//
// Converts year, day of year, hour, minute and second (any of the time parts
// and the day may be out of range, carried with floor semantics) into seconds
// since 1970-01-01 00:00:00. The pipeline has six register stages: three carry
// stages, a year carry stage, a day count stage and the seconds multiply that
// also serves as the output register. A new request is taken every cycle; an output
// stall holds the whole pipeline in place. Years that normalize to 1970 or
// earlier count only the day of year and the time of day.
module datetime_to_epoch_seconds_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dte_pkg::YearW-1:0]         in_year,
  input  logic signed [dte_pkg::DayW-1:0]   in_day_of_year,
  input  logic signed [dte_pkg::HourW-1:0]  in_hour,
  input  logic signed [dte_pkg::MinW-1:0]   in_minute,
  input  logic signed [dte_pkg::SecW-1:0]   in_second,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dte_pkg::EpochW-1:0]        out_epoch_seconds
);

  logic en;
  logic norm_valid;
  dte_pkg::norm_t norm;
  logic days_valid;
  logic [dte_pkg::DaysW-1:0] days;
  logic [dte_pkg::TodW-1:0] tod;
  logic out_valid_r;
  logic [dte_pkg::EpochW-1:0] epoch_r;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  dte_normalize u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(in_valid),
    .year(in_year), .day_of_year(in_day_of_year), .hour(in_hour),
    .minute(in_minute), .second(in_second),
    .valid_out(norm_valid), .norm(norm)
  );

  dte_days u_days (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(norm_valid), .norm(norm),
    .valid_out(days_valid), .days(days), .tod(tod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= days_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      epoch_r <= 37'(days) * 37'(dte_pkg::SecsPerDay) + 37'(tod);
    end
  end

  assign out_valid = out_valid_r;
  assign out_epoch_seconds = epoch_r;

  // carried time fields must land in their normal ranges
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    norm_valid |-> (norm.second < 6'd60 && norm.minute < 6'd60 && norm.hour < 5'd24))
    else $error("time of day carry out of range");

  // time of day seconds never reach a full day
  a_tod_secs: assert property (@(posedge clk) disable iff (!rst_n)
    days_valid |-> (tod < dte_pkg::SecsPerDay))
    else $error("time of day seconds out of range");

  // a stalled result is not replaced
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(epoch_r)))
    else $error("stalled result changed");

endmodule
